// ===== src/ebb_pkg.sv =====
// Package for the Erlang B blocking probability block.
// Holds the field widths, fixed-point constants and the sequencer state type.
// No dependencies.
package ebb_pkg;

  localparam int CHAN_W = 11;
  localparam int TRAF_W = 32;
  localparam int PROB_W = 32;
  localparam int NUM_W = 48;
  localparam int DIV_STEPS = 31;
  localparam int STEP_W = 5;

  localparam logic [PROB_W-1:0] ONE_Q31 = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DEN,
    ST_DIV
  } ebb_state_e;

endpackage

// ===== src/erlang_b_blocking_probability.sv =====
// Erlang B blocking probability: iterative recurrence with a shared multiplier
// and a radix-2 restoring divider under a small sequencer.
// Depends on ebb_pkg.

// A request is taken when start is high and busy is low. The block runs
// B <- A*B / (x + A*B) for x = 1..V from B = 1.0, with V clamped to MAX_CHANNELS,
// and reports B in Q1.31 on block_prob_o for one cycle, marked by done_o.
// The result cannot be held off: it must be taken in the cycle it appears.
// Each recurrence step passes through the 32x32 multiplier, then the denominator
// state and then the one-bit-per-cycle divider, which are reused for every step.
// For V = 0 the strobe comes in the cycle after the request is accepted. busy
// stays high until the result cycle, in which a new request may already be
// accepted.
module erlang_b_blocking_probability #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ebb_pkg::CHAN_W-1:0] channels_i,
  input  logic [ebb_pkg::TRAF_W-1:0] traffic_i,
  output logic                       done_o,
  output logic [ebb_pkg::PROB_W-1:0] block_prob_o
);
  import ebb_pkg::*;

  localparam logic [16:0] MaxCh = 17'(MAX_CHANNELS);

  ebb_state_e state_q, state_d;

  logic [TRAF_W-1:0] traffic_q;
  logic [PROB_W-1:0] b_q;
  logic [CHAN_W-1:0] v_q;
  logic [CHAN_W-1:0] x_q;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  den_q;
  logic [NUM_W-1:0]  rem_q;
  logic [DIV_STEPS-1:0] quo_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [PROB_W-1:0] result_q;

  logic              accept;
  logic [CHAN_W-1:0] v_eff;
  logic [63:0]       prod;
  logic [NUM_W:0]    rem_sh;
  logic [NUM_W:0]    rem_diff;
  logic              q_bit;
  logic [NUM_W-1:0]  rem_next;
  logic              last_step;
  logic              last_iter;

  assign accept = start && !busy;

  always_comb begin
    if ({6'b0, channels_i} > MaxCh) begin
      v_eff = MaxCh[CHAN_W-1:0];
    end else begin
      v_eff = channels_i;
    end
  end

  assign prod      = 64'(traffic_q) * 64'(b_q);
  assign rem_sh    = {rem_q, 1'b0};
  assign rem_diff  = rem_sh - {1'b0, den_q};
  assign q_bit     = (rem_sh >= {1'b0, den_q});
  assign rem_next  = q_bit ? rem_diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
  assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));
  assign last_iter = (x_q == v_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (v_eff != '0)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DEN;
      ST_DEN: state_d = ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          state_d = last_iter ? ST_IDLE : ST_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    unique case (state_q)
      ST_IDLE: busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  assign done_o       = done_q;
  assign block_prob_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_IDLE && accept && v_eff == '0) ||
                 (state_q == ST_DIV && last_step && last_iter);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          traffic_q <= traffic_i;
          b_q       <= ONE_Q31;
          v_q       <= v_eff;
          x_q       <= CHAN_W'(1);
          if (v_eff == '0) begin
            result_q <= ONE_Q31;
          end
        end
      end
      ST_MUL: begin
        num_q <= prod[63:16];
      end
      ST_DEN: begin
        den_q  <= num_q + {6'b0, x_q, 31'b0};
        rem_q  <= num_q;
        quo_q  <= '0;
        step_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_next;
        quo_q  <= {quo_q[DIV_STEPS-2:0], q_bit};
        step_q <= step_q + STEP_W'(1);
        if (last_step) begin
          b_q <= {1'b0, quo_q[DIV_STEPS-2:0], q_bit};
          x_q <= x_q + CHAN_W'(1);
          if (last_iter) begin
            result_q <= {1'b0, quo_q[DIV_STEPS-2:0], q_bit};
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (block_prob_o <= ONE_Q31))
    else $error("blocking probability above 1.0");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (x_q <= v_q && x_q != '0 && step_q < STEP_W'(DIV_STEPS)))
    else $error("recurrence counter out of range");
`endif

endmodule

// ===== tb/erlang_b_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Erlang B blocking probability block: predicts a result for each
// accepted request and compares it at the done strobe, in order. Depends on ebb_pkg.
module erlang_b_checker #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [ebb_pkg::CHAN_W-1:0] channels_i,
  input  logic [ebb_pkg::TRAF_W-1:0] traffic_i,
  input  logic                       done_i,
  input  logic [ebb_pkg::PROB_W-1:0] block_prob_i,
  output int                         errors_o,
  output int                         pending_o
);
  import ebb_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] channels;
    logic [TRAF_W-1:0] traffic;
    logic [PROB_W-1:0] prob;
  } blocking_beat_t;

  blocking_beat_t expected_prob_q[$];
  blocking_beat_t oldest;
  blocking_beat_t fresh;
  int mismatch_count = 0;
  int outstanding = 0;

  assign errors_o  = mismatch_count;
  assign pending_o = outstanding;

  function automatic logic [PROB_W-1:0] erlang_b_q31(input logic [CHAN_W-1:0] chan,
                                                     input logic [TRAF_W-1:0] traf);
    logic [63:0] prob;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    int steps;
    steps = (int'(chan) > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan);
    prob = 64'(ONE_Q31);
    for (int x = 1; x <= steps; x++) begin
      num = (64'(traf) * prob) >> 16;
      den = num + (64'(x) << 31);
      rem = num;
      prob = '0;
      for (int bit_idx = 0; bit_idx < DIV_STEPS; bit_idx++) begin
        rem = rem << 1;
        prob = prob << 1;
        if (rem >= den) begin
          rem = rem - den;
          prob[0] = 1'b1;
        end
      end
    end
    return prob[PROB_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_i) begin
        if (expected_prob_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding",
                                    block_prob_i));
        end else begin
          oldest = expected_prob_q.pop_front();
          if (block_prob_i !== oldest.prob) begin
            report_mismatch($sformatf("channels %0d traffic %h: prob %h, want %h",
                                      oldest.channels, oldest.traffic,
                                      block_prob_i, oldest.prob));
          end
        end
      end
      if (start_i && !busy_i) begin
        fresh.channels = channels_i;
        fresh.traffic  = traffic_i;
        fresh.prob     = erlang_b_q31(channels_i, traffic_i);
        expected_prob_q.push_back(fresh);
      end
      outstanding = expected_prob_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for erlang_b_blocking_probability: drives directed and random
// requests in bursts and gives the verdict. Needs ebb_pkg, the DUT and the checker.
module tb;
  import ebb_pkg::*;

  localparam int MaxChannels = 1024;
  localparam int WatchdogLimit = 200000;
  localparam int RandomRequests = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CHAN_W-1:0] channels = '0;
  logic [TRAF_W-1:0] traffic = '0;
  logic              done;
  logic [PROB_W-1:0] block_prob;
  int                errors;
  int                pending;
  int                idle_cycles = 0;
  int                burst_left = 0;

  always #10 clk = ~clk;

  erlang_b_blocking_probability #(
    .MAX_CHANNELS(MaxChannels)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .channels_i  (channels),
    .traffic_i   (traffic),
    .done_o      (done),
    .block_prob_o(block_prob)
  );

  erlang_b_checker #(
    .MAX_CHANNELS(MaxChannels)
  ) prob_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .channels_i  (channels),
    .traffic_i   (traffic),
    .done_i      (done),
    .block_prob_i(block_prob),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(input logic [CHAN_W-1:0] chan, input logic [TRAF_W-1:0] traf);
    int gap;
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start    <= 1'b1;
    channels <= chan;
    traffic  <= traf;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    logic [CHAN_W-1:0] chan;
    logic [TRAF_W-1:0] traf;
    int sel;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(11'd0, 32'h0000_0000);
    send_request(11'd0, 32'hFFFF_FFFF);
    send_request(11'd1, 32'h0000_0000);
    send_request(11'd1, 32'h0001_0000);
    send_request(11'd1, 32'hFFFF_FFFF);
    send_request(11'd2, 32'h0002_0000);
    send_request(11'd10, 32'h000A_0000);
    send_request(11'd10, 32'h0000_8000);
    send_request(11'd5, 32'h0000_0001);
    send_request(11'd3, 32'h0000_0100);
    send_request(11'd40, 32'h0000_0000);
    send_request(11'd40, 32'hFFFF_FFFF);
    send_request(11'd1024, 32'hFFFF_FFFF);
    send_request(11'd1025, 32'h0064_0000);
    send_request(11'd2047, 32'hFFFF_FFFF);
    send_request(11'd2047, 32'h0000_0000);
    send_request(11'd7, 32'h8000_0000);
    send_request(11'd20, 32'h0014_0000);

    for (int n = 0; n < RandomRequests; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        chan = CHAN_W'($urandom_range(0, 2047));
      end else if (sel < 20) begin
        chan = CHAN_W'($urandom_range(0, 3));
      end else begin
        chan = CHAN_W'($urandom_range(0, 48));
      end
      case ($urandom_range(0, 3))
        0: begin
          traf = $urandom();
        end
        1: begin
          traf = TRAF_W'($urandom_range(0, 255));
        end
        2: begin
          traf = TRAF_W'(($urandom_range(0, 64) << 16) | $urandom_range(0, 65535));
        end
        default: begin
          traf = TRAF_W'(($urandom_range(0, 2 * int'(chan) + 1) << 16)
                         | $urandom_range(0, 65535));
        end
      endcase
      send_request(chan, traf);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== erlang_b_blocking_probability.f =====
src/ebb_pkg.sv
src/erlang_b_blocking_probability.sv
tb/erlang_b_checker.sv
tb/tb.sv
